>>> src/dmsd_pkg.sv
// ----------------------------------------------------------------------------
// dmsd_pkg
// Shared types, sizes and helpers for the door mode and sensor debouncer.
// ----------------------------------------------------------------------------
package dmsd_pkg;

   // Window lengths of the two sliding majority filters.
   localparam int MODE_WINDOW = 10;
   localparam int REED_WINDOW = 200;

   // Register widths and reset values.
   localparam int MODE_TH_W   = 4;
   localparam int SENSOR_TH_W = 8;
   localparam logic [MODE_TH_W-1:0]   MODE_TH_RESET   = MODE_TH_W'(8);
   localparam logic [SENSOR_TH_W-1:0] SENSOR_TH_RESET = SENSOR_TH_W'(180);

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = SENSOR_TH_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_THRESHOLD   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_THRESHOLD = 1'b1;

   // Stream word widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      MODE_AUTO   = 2'd0,
      MODE_CLOSED = 2'd1,
      MODE_OPEN   = 2'd2
   } mode_type;

   // One sample handed from the input stage to both filters.
   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     reed;
   } step_type;

   // Throw pins to switch position: only a low, b high selects auto.
   function automatic mode_type decode_mode(input logic pin_a, input logic pin_b);
      mode_type m;
      if (!pin_a && pin_b) begin
         m = MODE_AUTO;
      end else if (!pin_a && !pin_b) begin
         m = MODE_CLOSED;
      end else begin
         m = MODE_OPEN;
      end
      return m;
   endfunction

endpackage

>>> src/dmsd_mode_window.sv
// ----------------------------------------------------------------------------
// dmsd_mode_window
// Sliding window over the decoded switch mode with running per-mode counts.
// ----------------------------------------------------------------------------
module dmsd_mode_window (
   input  logic                                clock,
   input  logic                                reset,
   input  dmsd_pkg::step_type                  step,
   input  logic [dmsd_pkg::MODE_TH_W-1:0]      mode_threshold,
   output dmsd_pkg::mode_type                  latched_mode_in
);
   import dmsd_pkg::*;

   localparam int PW   = $clog2(MODE_WINDOW);
   localparam int CW   = $clog2(MODE_WINDOW + 1);
   localparam int CMPW = (CW > MODE_TH_W) ? CW : MODE_TH_W;

   mode_type          ring_ff [MODE_WINDOW];
   logic [PW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     n_auto_ff, n_auto_in;
   logic [CW-1:0]     n_closed_ff, n_closed_in;
   logic [CW-1:0]     n_open;
   mode_type          latched_ff;
   mode_type          oldest;
   logic [CMPW-1:0]   th;

   assign oldest = ring_ff[ptr_ff];
   assign th     = CMPW'(mode_threshold);

   always_comb begin
      ptr_in          = ptr_ff;
      n_auto_in       = n_auto_ff;
      n_closed_in     = n_closed_ff;
      latched_mode_in = latched_ff;
      n_open          = '0;
      if (step.valid) begin
         ptr_in      = (ptr_ff == PW'(MODE_WINDOW - 1)) ? '0 : ptr_ff + PW'(1);
         // Entering sample counts in, the one it overwrites counts out.
         n_auto_in   = n_auto_ff + CW'(step.mode == MODE_AUTO)
                                 - CW'(oldest == MODE_AUTO);
         n_closed_in = n_closed_ff + CW'(step.mode == MODE_CLOSED)
                                   - CW'(oldest == MODE_CLOSED);
         n_open      = CW'(MODE_WINDOW) - n_auto_in - n_closed_in;
         if (CMPW'(n_auto_in) >= th) begin
            latched_mode_in = MODE_AUTO;
         end else if (CMPW'(n_closed_in) >= th) begin
            latched_mode_in = MODE_CLOSED;
         end else if (CMPW'(n_open) >= th) begin
            latched_mode_in = MODE_OPEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODE_WINDOW; i++) begin
            ring_ff[i] <= MODE_AUTO;
         end
         ptr_ff      <= '0;
         n_auto_ff   <= CW'(MODE_WINDOW);
         n_closed_ff <= '0;
         latched_ff  <= MODE_AUTO;
      end else begin
         if (step.valid) begin
            ring_ff[ptr_ff] <= step.mode;
         end
         ptr_ff      <= ptr_in;
         n_auto_ff   <= n_auto_in;
         n_closed_ff <= n_closed_in;
         latched_ff  <= latched_mode_in;
      end
   end

endmodule

>>> src/dmsd_reed_window.sv
// ----------------------------------------------------------------------------
// dmsd_reed_window
// Sliding window over the reed pin, kept in a memory, with a running count.
// ----------------------------------------------------------------------------
module dmsd_reed_window (
   input  logic                                clock,
   input  logic                                reset,
   input  dmsd_pkg::step_type                  step,
   input  logic [dmsd_pkg::SENSOR_TH_W-1:0]    sensor_threshold,
   output logic                                latched_closed_in
);
   import dmsd_pkg::*;

   localparam int PW = $clog2(REED_WINDOW);
   localparam int CW = $clog2(REED_WINDOW + 1);

   logic              reed_mem [REED_WINDOW];
   logic [PW-1:0]     ptr_ff, ptr_in;
   logic [PW-1:0]     rd_addr;
   logic              rd_ff;
   logic              wrapped_ff, wrapped_in;
   logic [CW-1:0]     n_high_ff, n_high_in;
   logic [CW-1:0]     n_low;
   logic              latched_ff;
   logic              oldest;

   // Entries are only trusted once the pointer has gone all the way round;
   // before that the overwritten entry is read as zero, as the memory has no reset.
   assign oldest = wrapped_ff & rd_ff;

   always_comb begin
      ptr_in            = (ptr_ff == PW'(REED_WINDOW - 1)) ? '0 : ptr_ff + PW'(1);
      wrapped_in        = wrapped_ff;
      n_high_in         = n_high_ff;
      n_low             = '0;
      latched_closed_in = latched_ff;
      // Prefetch the entry that the next sample will overwrite.
      rd_addr           = step.valid ? ptr_in : ptr_ff;
      if (step.valid) begin
         wrapped_in = wrapped_ff | (ptr_ff == PW'(REED_WINDOW - 1));
         n_high_in  = n_high_ff + CW'(step.reed) - CW'(oldest);
         n_low      = CW'(REED_WINDOW) - n_high_in;
         if (SENSOR_TH_W'(n_high_in) >= sensor_threshold) begin
            latched_closed_in = 1'b1;
         end else if (SENSOR_TH_W'(n_low) >= sensor_threshold) begin
            latched_closed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step.valid) begin
         reed_mem[ptr_ff] <= step.reed;
      end
      rd_ff <= reed_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         wrapped_ff <= 1'b0;
         n_high_ff  <= '0;
         latched_ff <= 1'b0;
      end else begin
         if (step.valid) begin
            ptr_ff <= ptr_in;
         end
         wrapped_ff <= wrapped_in;
         n_high_ff  <= n_high_in;
         latched_ff <= latched_closed_in;
      end
   end

endmodule

>>> src/door_mode_and_sensor_debouncer_unit.sv
// ----------------------------------------------------------------------------
// door_mode_and_sensor_debouncer_unit
// Sliding-window majority debounce of a three-position switch and a reed pin.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word contents (lowest bit first)
//   req_     in         pin_a, pin_b, reed_level
//   rsp_     out        mode[1:0], sensor_closed, reported_state
//   csr_     in         index 0 mode_threshold, index 1 sensor_threshold
//
// One word is accepted per cycle while the result stream does not stall, and
// every accepted word yields exactly one result word: the word waits in the
// input register while the combinational window update between it and the
// result register computes its result.
// The rate rests on the running counts: each window keeps running counts that
// are updated from the entering and the leaving sample in one add and subtract.
// The reed window lives in a 200-entry memory whose read port prefetches the
// entry to be overwritten; a fill flag makes unwritten entries read as zero,
// so there is no clearing pass and words are taken right after reset.
// When rsp_tready is low the result register holds and the input register
// still takes one more word before req_tready drops.
//
module door_mode_and_sensor_debouncer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [dmsd_pkg::REQ_DATA_W-1:0]       req_tdata,  // pin_a, pin_b, reed_level
   // Result stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dmsd_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // mode[1:0], sensor_closed,
                                                             // reported_state
   // Configuration writes.
   input  logic                                  csr_we,
   input  logic [dmsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dmsd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dmsd_pkg::*;

   // Threshold registers.
   logic [MODE_TH_W-1:0]   mode_th_ff;
   logic [SENSOR_TH_W-1:0] sensor_th_ff;

   // Input register holding the raw pins of one word.
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_pin_a_ff, s1_pin_b_ff, s1_reed_ff;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   mode_type rsp_mode_ff;
   logic     rsp_closed_ff;
   logic     rsp_reported_ff;

   logic     req_accept;
   logic     advance;
   step_type step;
   mode_type latched_mode_in;
   logic     latched_closed_in;
   logic     reported_in;

   // The input register moves on whenever the result register is free or is
   // being emptied in the same cycle.
   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign step.valid = advance;
   assign step.mode  = decode_mode(s1_pin_a_ff, s1_pin_b_ff);
   assign step.reed  = s1_reed_ff;

   dmsd_mode_window u_mode_window (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .mode_threshold  (mode_th_ff),
      .latched_mode_in (latched_mode_in)
   );

   dmsd_reed_window u_reed_window (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .sensor_threshold  (sensor_th_ff),
      .latched_closed_in (latched_closed_in)
   );

   // In auto the door state follows the reed sensor; in manual it reports
   // one when the switch selects open.
   assign reported_in = (latched_mode_in == MODE_AUTO) ? latched_closed_in
                                                       : (latched_mode_in == MODE_OPEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_th_ff   <= MODE_TH_RESET;
         sensor_th_ff <= SENSOR_TH_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE_THRESHOLD:   mode_th_ff   <= csr_wdata[MODE_TH_W-1:0];
               CSR_SENSOR_THRESHOLD: sensor_th_ff <= csr_wdata[SENSOR_TH_W-1:0];
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pin_a_ff <= req_tdata[0];
         s1_pin_b_ff <= req_tdata[1];
         s1_reed_ff  <= req_tdata[2];
      end
      if (advance) begin
         rsp_mode_ff     <= latched_mode_in;
         rsp_closed_ff   <= latched_closed_in;
         rsp_reported_ff <= reported_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_reported_ff, rsp_closed_ff, rsp_mode_ff};

`ifndef SYNTH
   // Auto mode reports the debounced sensor.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == MODE_AUTO) |-> (rsp_tdata[3] == rsp_tdata[2]))
      else $error("auto mode result does not report the sensor state");

   // Manual modes report one only for open.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != MODE_AUTO) |->
         (rsp_tdata[3] == (rsp_tdata[1:0] == MODE_OPEN)))
      else $error("manual mode result reports the wrong state");

   // An accepted word always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted word lost from the input register");

   // A word that cannot advance stays put in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=>
         (s1_valid_ff && $stable(s1_pin_a_ff) && $stable(s1_pin_b_ff) && $stable(s1_reed_ff)))
      else $error("stalled word changed in the input register");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the door mode and sensor debouncer. Switch and reed
// words are streamed in with random bursts and gaps. The result stream stalls
// on its own pattern. A behavioral copy of both sliding windows predicts every
// result word, and the bench compares the words field by field.
// ----------------------------------------------------------------------------
module testbench;
   import dmsd_pkg::*;

   // A cycle with no word moving on either stream counts toward this limit.
   localparam int IDLE_LIMIT = 2000;

   // These are the receiver stall styles, which the receiver draws at random.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   // These are the fields of one result word, in the order they appear in rsp_tdata.
   typedef struct {
      mode_type mode;
      logic     closed;
      logic     reported;
   } door_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // pin_a, pin_b, reed_level
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // mode[1:0], sensor_closed, reported_state
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   door_mode_and_sensor_debouncer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // The predictor keeps its own copy of the thresholds, both rings and the
   // latched values. All of them start at the values they take after reset.
   int       mode_limit   = int'(MODE_TH_RESET);
   int       reed_limit   = int'(SENSOR_TH_RESET);
   mode_type mode_hist [MODE_WINDOW] = '{default: MODE_AUTO};
   logic     reed_hist [REED_WINDOW] = '{default: 1'b0};
   int       mode_slot    = 0;
   int       reed_slot    = 0;
   mode_type held_mode    = MODE_AUTO;
   logic     held_closed  = 1'b0;

   door_status_type pending_status[$];

   int accepted_words    = 0;
   int results_seen      = 0;
   int mismatch_count    = 0;
   int settings_written  = 0;
   int idle_cycles       = 0;

   // This is the state of the sender's burst pattern and of the run-based stimulus.
   int         burst_left      = 0;
   int         switch_run_left = 0;
   int         reed_run_left   = 0;
   logic [1:0] switch_pins     = 2'b10;   // The switch starts in auto: b high, a low.
   logic       reed_now        = 1'b0;

   // This task advances the predicted debouncer by one accepted input word and
   // queues the status word that the block must return for it.
   task automatic debounce_tick(input logic pin_a, input logic pin_b, input logic reed);
      mode_type        pos;
      int              n_auto;
      int              n_closed;
      int              n_open;
      int              n_high;
      door_status_type status;
      if (!pin_a && pin_b) begin
         pos = MODE_AUTO;
      end else if (!pin_a && !pin_b) begin
         pos = MODE_CLOSED;
      end else begin
         pos = MODE_OPEN;
      end
      mode_hist[mode_slot] = pos;
      mode_slot = (mode_slot + 1 == MODE_WINDOW) ? 0 : mode_slot + 1;
      reed_hist[reed_slot] = reed;
      reed_slot = (reed_slot + 1 == REED_WINDOW) ? 0 : reed_slot + 1;

      n_auto = 0;
      n_closed = 0;
      n_open = 0;
      for (int i = 0; i < MODE_WINDOW; i++) begin
         case (mode_hist[i])
            MODE_AUTO: begin
               n_auto++;
            end
            MODE_CLOSED: begin
               n_closed++;
            end
            default: begin
               n_open++;
            end
         endcase
      end
      n_high = 0;
      for (int i = 0; i < REED_WINDOW; i++) begin
         if (reed_hist[i]) begin
            n_high++;
         end
      end

      // Auto wins a tie, then closed, then open. If none reaches the
      // threshold, the latched mode holds.
      if (n_auto >= mode_limit) begin
         held_mode = MODE_AUTO;
      end else if (n_closed >= mode_limit) begin
         held_mode = MODE_CLOSED;
      end else if (n_open >= mode_limit) begin
         held_mode = MODE_OPEN;
      end
      if (n_high >= reed_limit) begin
         held_closed = 1'b1;
      end else if (REED_WINDOW - n_high >= reed_limit) begin
         held_closed = 1'b0;
      end

      status.mode     = held_mode;
      status.closed   = held_closed;
      status.reported = (held_mode == MODE_AUTO) ? held_closed : (held_mode == MODE_OPEN);
      pending_status.push_back(status);
   endtask

   // The receiver stalls on its own pattern. Each drawn style holds until the next
   // draw, so long stretches with no stall occur as well.
   always @(posedge clock) begin : receiver
      int              cycle_count;
      stall_style_type style;
      cycle_count++;
      if (cycle_count % 96 == 0) begin
         style = stall_style_type'($urandom_range(0, 3));
      end
      case (style)
         STALL_NONE: begin
            rsp_tready <= 1'b1;
         end
         STALL_LIGHT: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         STALL_HEAVY: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= (cycle_count % 3 != 0);
         end
      endcase
   end

   // This block watches all three ports at each rising edge. It sees the values
   // from before the edge, so the order of events within a step cannot change
   // what it records.
   always @(posedge clock) begin : monitor
      door_status_type want;
      logic [1:0]      got_mode;
      logic            got_closed;
      logic            got_reported;
      logic            moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_we) begin
            if (csr_index == CSR_MODE_THRESHOLD) begin
               mode_limit = int'(csr_wdata[MODE_TH_W-1:0]);
            end else if (csr_index == CSR_SENSOR_THRESHOLD) begin
               reed_limit = int'(csr_wdata[SENSOR_TH_W-1:0]);
            end
         end
         if (req_tvalid && req_tready) begin
            debounce_tick(req_tdata[0], req_tdata[1], req_tdata[2]);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            got_mode     = rsp_tdata[1:0];
            got_closed   = rsp_tdata[2];
            got_reported = rsp_tdata[3];
            if (pending_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: result word %h arrived with nothing expected", rsp_tdata);
               end
            end else begin
               want = pending_status.pop_front();
               if (got_mode !== want.mode || got_closed !== want.closed ||
                   got_reported !== want.reported) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("ERROR: result %0d mode/closed/reported expected %0d/%0b/%0b, got %0d/%0b/%0b",
                              results_seen, want.mode, want.closed, want.reported,
                              got_mode, got_closed, got_reported);
                  end
               end
            end
         end
         // The watchdog ends a run that has stopped moving words.
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // This task sends one input word. The sender works in bursts: when a burst
   // runs out, it may drop tvalid for a random gap before it starts the next one.
   task automatic send_word(input logic pin_a, input logic pin_b, input logic reed);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - 3){1'b0}}, reed, pin_b, pin_a};
      do @(posedge clock); while (!req_tready);
      accepted_words++;
   endtask

   // This task stops the sender and waits until every accepted word has its
   // result. It then lets the pipeline empty before it returns.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (results_seen < accepted_words) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Thresholds are changed only while the block is idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_written++;
   endtask

   // This task sends switch positions and reed levels in runs. Long clean runs
   // fill a window far enough to reach high thresholds. The noise percentages
   // add single-word glitches that the majority vote must ride out.
   task automatic send_runs(input int count, input int switch_run_max,
                            input int reed_run_min, input int reed_run_max,
                            input int pin_noise_pct, input int reed_noise_pct);
      logic pin_a;
      logic pin_b;
      logic reed;
      for (int i = 0; i < count; i++) begin
         if (switch_run_left == 0) begin
            switch_pins = 2'($urandom_range(0, 3));
            switch_run_left = $urandom_range(1, switch_run_max);
         end
         if (reed_run_left == 0) begin
            reed_now = ~reed_now;
            reed_run_left = $urandom_range(reed_run_min, reed_run_max);
         end
         switch_run_left--;
         reed_run_left--;
         {pin_b, pin_a} = switch_pins;
         reed = reed_now;
         if ($urandom_range(1, 100) <= pin_noise_pct) begin
            {pin_b, pin_a} = 2'($urandom_range(0, 3));
         end
         if ($urandom_range(1, 100) <= reed_noise_pct) begin
            reed = ~reed;
         end
         send_word(pin_a, pin_b, reed);
      end
   endtask

   // This test covers each pin combination and the threshold extremes.
   // Thresholds of 1 let one word latch a value. A zero threshold latches auto
   // and closed on every word. Thresholds above the window can never fire.
   // Upper data bits written to the 4-bit mode register must be ignored.
   task automatic test_directed();
      write_register(CSR_MODE_THRESHOLD, 8'd1);
      write_register(CSR_SENSOR_THRESHOLD, 8'd1);
      for (int i = 0; i < 8; i++) begin
         send_word(i[0], i[1], i[2]);
      end
      write_register(CSR_MODE_THRESHOLD, 8'd0);
      write_register(CSR_SENSOR_THRESHOLD, 8'd0);
      send_word(1'b1, 1'b1, 1'b0);
      send_word(1'b0, 1'b0, 1'b0);
      send_word(1'b1, 1'b0, 1'b0);
      send_word(1'b0, 1'b1, 1'b0);
      write_register(CSR_MODE_THRESHOLD, 8'd15);
      write_register(CSR_SENSOR_THRESHOLD, 8'd255);
      send_word(1'b0, 1'b0, 1'b1);
      send_word(1'b1, 1'b1, 1'b1);
      send_word(1'b0, 1'b1, 1'b0);
      send_word(1'b1, 1'b0, 1'b1);
      write_register(CSR_MODE_THRESHOLD, 8'hF5);
      write_register(CSR_SENSOR_THRESHOLD, 8'd201);
      send_word(1'b1, 1'b1, 1'b1);
      send_word(1'b1, 1'b1, 1'b0);
      send_word(1'b0, 1'b0, 1'b1);
      send_word(1'b0, 1'b0, 1'b0);
   endtask

   // This test uses the thresholds that the block has after reset. Reed runs
   // are long enough that the 180-of-200 vote can swing both ways.
   task automatic test_default_thresholds();
      write_register(CSR_MODE_THRESHOLD, CSR_DATA_W'(MODE_TH_RESET));
      write_register(CSR_SENSOR_THRESHOLD, SENSOR_TH_RESET);
      send_runs(260, 12, 120, 230, 4, 3);
   endtask

   // This test uses random thresholds, low ones in the first half, and short,
   // noisy runs, so the latched values change often. The sender pauses until all
   // results are in before the second half.
   task automatic test_small_thresholds();
      write_register(CSR_MODE_THRESHOLD, CSR_DATA_W'($urandom_range(1, 4)));
      write_register(CSR_SENSOR_THRESHOLD, CSR_DATA_W'($urandom_range(1, 30)));
      send_runs(60, 6, 1, 40, 10, 10);
      write_register(CSR_MODE_THRESHOLD, CSR_DATA_W'($urandom_range(1, 10)));
      write_register(CSR_SENSOR_THRESHOLD, CSR_DATA_W'($urandom_range(1, 200)));
      send_runs(60, 6, 1, 40, 10, 10);
   endtask

   // This test requires full windows. The reed runs have no glitches, so a
   // whole window of one level can form. The switch pins still glitch
   // sometimes, which can keep the 10-of-10 vote from firing.
   task automatic test_full_windows();
      write_register(CSR_MODE_THRESHOLD, 8'd10);
      write_register(CSR_SENSOR_THRESHOLD, 8'd200);
      send_runs(250, 25, 200, 240, 3, 0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_default_thresholds();
      test_small_thresholds();
      test_full_windows();
      wait_for_results();
      repeat (6) @(posedge clock);
      $display("Sent %0d switch/reed words and checked %0d status words", accepted_words,
               results_seen);
      $display("across %0d threshold writes, including zero and out-of-window values.",
               settings_written);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_status.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
src/dmsd_pkg.sv
src/dmsd_mode_window.sv
src/dmsd_reed_window.sv
src/door_mode_and_sensor_debouncer_unit.sv
tb/sv/testbench.sv
